// ===== src/state_variable_filter_macros.svh =====
// Assertion macros shared by the state variable filter RTL.
// No dependencies; include by bare file name.
`ifndef STATE_VARIABLE_FILTER_MACROS_SVH
`define STATE_VARIABLE_FILTER_MACROS_SVH

// Checked only while out of reset.
`define SVF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SVF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/svf_pkg.sv =====
// Shared widths, types and fixed-point helpers for the state variable filter.
// No dependencies.
package svf_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int STATE_W     = 32;
    localparam int FREQ_W      = 18;
    localparam int DAMP_W      = 20;
    localparam int GAIN_W      = 16;
    localparam int COEFF_SHIFT = 16;
    localparam int GAIN_SHIFT  = 12;

    localparam int MUL_A_W = STATE_W;
    localparam int MUL_B_W = (DAMP_W + 1 > GAIN_W) ? DAMP_W + 1 : GAIN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int WIDE_W  = PROD_W - COEFF_SHIFT + 2;

    localparam int NUM_RESP   = 4;
    localparam int RESP_IDX_W = $clog2(NUM_RESP);

    localparam logic [DAMP_W-1:0] DAMP_MAX = DAMP_W'(8 << COEFF_SHIFT);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FB,
        ST_QB,
        ST_HP,
        ST_FH,
        ST_BP,
        ST_GAIN,
        ST_GLAST,
        ST_DONE
    } svf_state_t;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_op_t;

    // floor(p / 2^16), sign-extended to the internal work width
    function automatic logic signed [WIDE_W-1:0] coeff_scale(
        input logic signed [PROD_W-1:0] p
    );
        return WIDE_W'(p >>> COEFF_SHIFT);
    endfunction

    function automatic logic in_state_range(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-STATE_W:0] top;
        top = v[WIDE_W-1:STATE_W-1];
        return (&top) || (~|top);
    endfunction

    // floor(p / 2^12), saturated to the signed sample range
    function automatic logic signed [SAMPLE_W-1:0] gain_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0]   s;
        logic [PROD_W-SAMPLE_W:0]   top;
        s   = p >>> GAIN_SHIFT;
        top = s[PROD_W-1:SAMPLE_W-1];
        if ((&top) || (~|top)) begin
            return s[SAMPLE_W-1:0];
        end else if (s[PROD_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== src/state_variable_filter.sv =====
// Chamberlin state variable filter, top level: sequencer, state and output beat.
// Depends on svf_pkg, svf_mul and state_variable_filter_macros.svh.
//
// Each accepted sample runs the sequencer from idle through its product states to its
// result beat, and the next sample is taken once the sequencer is back in idle: every
// product (three coefficient products and four gain products) goes through the single
// registered multiplier in svf_mul, one product per cycle. A finished result
// waits in the output register while the next sample is accepted and worked on.
// On internal overflow both integrator states and all responses are cleared and
// fault is set for that beat.
`include "state_variable_filter_macros.svh"

module state_variable_filter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [svf_pkg::SAMPLE_W-1:0]  s_sample_in,
    input  logic        [svf_pkg::FREQ_W-1:0]    s_freq_coeff,
    input  logic        [svf_pkg::DAMP_W-1:0]    s_damp_coeff,
    input  logic signed [svf_pkg::GAIN_W-1:0]    s_gain_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [svf_pkg::SAMPLE_W-1:0]  m_lowpass_out,
    output logic signed [svf_pkg::SAMPLE_W-1:0]  m_highpass_out,
    output logic signed [svf_pkg::SAMPLE_W-1:0]  m_bandpass_out,
    output logic signed [svf_pkg::SAMPLE_W-1:0]  m_notch_out,
    output logic                                 m_fault
);

    svf_pkg::svf_state_t state_reg, state_next;

    logic [svf_pkg::RESP_IDX_W-1:0] k_reg, k_next;
    logic [svf_pkg::RESP_IDX_W-1:0] cap_idx;
    logic                           m_valid_reg, m_valid_next;
    logic                           ok_reg;
    logic                           fault_reg;
    logic                           out_load;

    logic signed [svf_pkg::SAMPLE_W-1:0] x_reg;
    logic        [svf_pkg::FREQ_W-1:0]   f_reg;
    logic        [svf_pkg::DAMP_W-1:0]   q_reg;
    logic signed [svf_pkg::GAIN_W-1:0]   g_reg;

    logic signed [svf_pkg::STATE_W-1:0]  band_reg;
    logic signed [svf_pkg::STATE_W-1:0]  low_reg;
    logic signed [svf_pkg::WIDE_W-1:0]   lp_reg;
    logic signed [svf_pkg::WIDE_W-1:0]   hp_reg;
    logic signed [svf_pkg::STATE_W-1:0]  resp_reg [svf_pkg::NUM_RESP];
    logic signed [svf_pkg::SAMPLE_W-1:0] res_reg  [svf_pkg::NUM_RESP];

    logic signed [svf_pkg::SAMPLE_W-1:0] m_lp_reg, m_hp_reg, m_bp_reg, m_br_reg;
    logic                                m_fault_reg;

    logic signed [svf_pkg::WIDE_W-1:0]   scaled;
    logic signed [svf_pkg::WIDE_W-1:0]   bp_wide;
    logic signed [svf_pkg::WIDE_W-1:0]   br_wide;
    logic                                ok_final;

    svf_pkg::mul_op_t                    mul_op;
    logic signed [svf_pkg::PROD_W-1:0]   prod;

    svf_mul u_mul (
        .aclk (aclk),
        .op   (mul_op),
        .prod (prod)
    );

    assign scaled   = svf_pkg::coeff_scale(prod);
    assign bp_wide  = scaled + svf_pkg::WIDE_W'(band_reg);
    assign br_wide  = hp_reg + lp_reg;
    assign ok_final = ok_reg && svf_pkg::in_state_range(bp_wide)
                      && svf_pkg::in_state_range(br_wide);
    assign out_load = (state_reg == svf_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            svf_pkg::ST_IDLE:  if (s_valid) state_next = svf_pkg::ST_FB;
            svf_pkg::ST_FB:    state_next = svf_pkg::ST_QB;
            svf_pkg::ST_QB:    state_next = svf_pkg::ST_HP;
            svf_pkg::ST_HP:    state_next = svf_pkg::ST_FH;
            svf_pkg::ST_FH:    state_next = svf_pkg::ST_BP;
            svf_pkg::ST_BP:    state_next = svf_pkg::ST_GAIN;
            svf_pkg::ST_GAIN: begin
                if (k_reg == svf_pkg::RESP_IDX_W'(svf_pkg::NUM_RESP - 1)) begin
                    state_next = svf_pkg::ST_GLAST;
                end
            end
            svf_pkg::ST_GLAST: state_next = svf_pkg::ST_DONE;
            svf_pkg::ST_DONE:  if (!m_valid_reg || m_ready) state_next = svf_pkg::ST_IDLE;
            default:           state_next = svf_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        mul_op.a = band_reg;
        mul_op.b = $signed(svf_pkg::MUL_B_W'(f_reg));
        k_next   = k_reg;
        cap_idx  = k_reg - svf_pkg::RESP_IDX_W'(1);
        unique case (state_reg)
            svf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                k_next  = '0;
            end
            svf_pkg::ST_QB: begin
                mul_op.b = $signed(svf_pkg::MUL_B_W'(q_reg));
            end
            svf_pkg::ST_FH: begin
                mul_op.a = $signed(hp_reg[svf_pkg::STATE_W-1:0]);
            end
            svf_pkg::ST_GAIN: begin
                mul_op.a = resp_reg[k_reg];
                mul_op.b = svf_pkg::MUL_B_W'(g_reg);
                k_next   = k_reg + svf_pkg::RESP_IDX_W'(1);
            end
            svf_pkg::ST_GLAST: begin
                cap_idx = svf_pkg::RESP_IDX_W'(svf_pkg::NUM_RESP - 1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= svf_pkg::ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            band_reg    <= '0;
            low_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == svf_pkg::ST_BP) begin
                if (ok_final) begin
                    band_reg <= bp_wide[svf_pkg::STATE_W-1:0];
                    low_reg  <= lp_reg[svf_pkg::STATE_W-1:0];
                end else begin
                    band_reg <= '0;
                    low_reg  <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_sample_in;
            f_reg <= s_freq_coeff;
            q_reg <= (s_damp_coeff > svf_pkg::DAMP_MAX) ? svf_pkg::DAMP_MAX : s_damp_coeff;
            g_reg <= s_gain_in;
        end
        if (state_reg == svf_pkg::ST_QB) begin
            lp_reg <= svf_pkg::WIDE_W'(low_reg) + scaled;
        end
        if (state_reg == svf_pkg::ST_HP) begin
            hp_reg <= svf_pkg::WIDE_W'(x_reg) - lp_reg - scaled;
            ok_reg <= svf_pkg::in_state_range(lp_reg);
        end
        if (state_reg == svf_pkg::ST_FH) begin
            ok_reg <= ok_reg && svf_pkg::in_state_range(hp_reg);
        end
        if (state_reg == svf_pkg::ST_BP) begin
            fault_reg <= !ok_final;
            if (ok_final) begin
                resp_reg[0] <= lp_reg[svf_pkg::STATE_W-1:0];
                resp_reg[1] <= hp_reg[svf_pkg::STATE_W-1:0];
                resp_reg[2] <= bp_wide[svf_pkg::STATE_W-1:0];
                resp_reg[3] <= br_wide[svf_pkg::STATE_W-1:0];
            end else begin
                for (int i = 0; i < svf_pkg::NUM_RESP; i++) begin
                    resp_reg[i] <= '0;
                end
            end
        end
        if ((state_reg == svf_pkg::ST_GAIN && k_reg != '0)
            || state_reg == svf_pkg::ST_GLAST) begin
            res_reg[cap_idx] <= svf_pkg::gain_sat(prod);
        end
        if (out_load) begin
            m_lp_reg    <= res_reg[0];
            m_hp_reg    <= res_reg[1];
            m_bp_reg    <= res_reg[2];
            m_br_reg    <= res_reg[3];
            m_fault_reg <= fault_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_lowpass_out  = m_lp_reg;
    assign m_highpass_out = m_hp_reg;
    assign m_bandpass_out = m_bp_reg;
    assign m_notch_out    = m_br_reg;
    assign m_fault        = m_fault_reg;

    `SVF_ASSERT(a_accept_starts, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == svf_pkg::ST_FB), "accepted beat did not start the sequence")
    `SVF_ASSERT(a_state_hold, aclk, aresetn, (aresetn && state_reg != svf_pkg::ST_BP) |=> ($stable(band_reg) && $stable(low_reg)), "integrator state changed outside update step")
    `SVF_ASSERT(a_fault_zero, aclk, aresetn, (m_valid && m_fault) |-> (m_lowpass_out == '0 && m_highpass_out == '0 && m_bandpass_out == '0 && m_notch_out == '0), "fault beat carries nonzero response")
    `SVF_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == svf_pkg::ST_IDLE && !m_valid), "reset did not idle the block")

endmodule

// ===== src/svf_mul.sv =====
// Shared registered signed multiplier of the state variable filter.
// Depends on svf_pkg.
module svf_mul (
    input  logic                              aclk,
    input  svf_pkg::mul_op_t                  op,
    output logic signed [svf_pkg::PROD_W-1:0] prod
);

    logic signed [svf_pkg::PROD_W-1:0] prod_reg;
    logic signed [svf_pkg::PROD_W-1:0] prod_next;

    assign prod_next = svf_pkg::PROD_W'(op.a) * svf_pkg::PROD_W'(op.b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== sim/state_variable_filter_tb.sv =====
// Self-checking testbench for state_variable_filter: drives samples with coefficients, predicts
// the four gained responses and the fault flag per beat, and compares every result beat.
// Depends on svf_pkg and the state_variable_filter RTL.
module state_variable_filter_tb;

    localparam int    HOLD_CYCLES    = 300;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    SETTLE_CYCLES  = 24;
    localparam int    MAX_REPORTS    = 10;
    localparam longint STATE_LIM     = 64'sd1 <<< (svf_pkg::STATE_W - 1);
    localparam longint SAMPLE_LIM    = 64'sd1 <<< (svf_pkg::SAMPLE_W - 1);

    typedef struct {
        logic signed [svf_pkg::SAMPLE_W-1:0] lowpass;
        logic signed [svf_pkg::SAMPLE_W-1:0] highpass;
        logic signed [svf_pkg::SAMPLE_W-1:0] bandpass;
        logic signed [svf_pkg::SAMPLE_W-1:0] notch;
        logic                                fault;
    } response_t;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic signed [svf_pkg::SAMPLE_W-1:0] s_sample_in    = '0;
    logic        [svf_pkg::FREQ_W-1:0]   s_freq_coeff   = '0;
    logic        [svf_pkg::DAMP_W-1:0]   s_damp_coeff   = '0;
    logic signed [svf_pkg::GAIN_W-1:0]   s_gain_in      = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic signed [svf_pkg::SAMPLE_W-1:0] m_lowpass_out;
    logic signed [svf_pkg::SAMPLE_W-1:0] m_highpass_out;
    logic signed [svf_pkg::SAMPLE_W-1:0] m_bandpass_out;
    logic signed [svf_pkg::SAMPLE_W-1:0] m_notch_out;
    logic                                m_fault;

    longint    band_acc = 0;
    longint    low_acc  = 0;
    response_t expected_responses[$];
    int        mismatches      = 0;
    int        idle_cycles     = 0;
    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;
    int        holds_requested = 0;
    int        holds_served    = 0;

    state_variable_filter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .s_freq_coeff  (s_freq_coeff),
        .s_damp_coeff  (s_damp_coeff),
        .s_gain_in     (s_gain_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_lowpass_out (m_lowpass_out),
        .m_highpass_out(m_highpass_out),
        .m_bandpass_out(m_bandpass_out),
        .m_notch_out   (m_notch_out),
        .m_fault       (m_fault)
    );

    always #6 aclk = ~aclk;

    function automatic longint coeff_product(input longint c, input longint d);
        return (c * d) >>> svf_pkg::COEFF_SHIFT;
    endfunction

    function automatic bit fits_state(input longint v);
        return (v >= -STATE_LIM) && (v < STATE_LIM);
    endfunction

    function automatic logic signed [svf_pkg::SAMPLE_W-1:0] scale_gain(input longint y,
                                                                       input longint g);
        longint p;
        p = (y * g) >>> svf_pkg::GAIN_SHIFT;
        if (p >= SAMPLE_LIM) begin
            p = SAMPLE_LIM - 1;
        end else if (p < -SAMPLE_LIM) begin
            p = -SAMPLE_LIM;
        end
        return svf_pkg::SAMPLE_W'(p);
    endfunction

    // Advances the integrators by the accepted beat and queues its response.
    task automatic predict_response();
        longint    x, f, q, g, lp, hp, bp, br;
        bit        ok;
        response_t r;
        x  = longint'(s_sample_in);
        f  = longint'(s_freq_coeff);
        q  = (s_damp_coeff > svf_pkg::DAMP_MAX) ? longint'(svf_pkg::DAMP_MAX)
                                                : longint'(s_damp_coeff);
        g  = longint'(s_gain_in);
        hp = 0;
        bp = 0;
        br = 0;
        lp = low_acc + coeff_product(f, band_acc);
        ok = fits_state(lp);
        if (ok) begin
            hp = x - lp - coeff_product(q, band_acc);
            ok = fits_state(hp);
        end
        if (ok) begin
            bp = coeff_product(f, hp) + band_acc;
            br = hp + lp;
            ok = fits_state(bp) && fits_state(br);
        end
        if (!ok) begin
            lp = 0;
            hp = 0;
            bp = 0;
            br = 0;
        end
        band_acc   = bp;
        low_acc    = lp;
        r.lowpass  = scale_gain(lp, g);
        r.highpass = scale_gain(hp, g);
        r.bandpass = scale_gain(bp, g);
        r.notch    = scale_gain(br, g);
        r.fault    = !ok;
        expected_responses.push_back(r);
    endtask

    task automatic check_response();
        response_t r;
        if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("unexpected beat: lp=%0d hp=%0d bp=%0d notch=%0d fault=%0b",
                         m_lowpass_out, m_highpass_out, m_bandpass_out, m_notch_out, m_fault);
            end
        end else begin
            r = expected_responses.pop_front();
            if (m_lowpass_out !== r.lowpass || m_highpass_out !== r.highpass ||
                m_bandpass_out !== r.bandpass || m_notch_out !== r.notch ||
                m_fault !== r.fault) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: exp lp=%0d hp=%0d bp=%0d notch=%0d fault=%0b",
                             r.lowpass, r.highpass, r.bandpass, r.notch, r.fault);
                    $display("          got lp=%0d hp=%0d bp=%0d notch=%0d fault=%0b",
                             m_lowpass_out, m_highpass_out, m_bandpass_out, m_notch_out,
                             m_fault);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_response();
        end
        if (aresetn && m_valid && m_ready) begin
            check_response();
        end
        idle_cycles <= ((s_valid && s_ready) || (m_valid && m_ready)) ? 0 : idle_cycles + 1;
    end

    // Receiver: random stalls, plus long hold-offs on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_served != holds_requested) begin
                holds_served++;
                repeat (HOLD_CYCLES - 1) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_sample(input logic signed [svf_pkg::SAMPLE_W-1:0] x,
                               input logic        [svf_pkg::FREQ_W-1:0]   f,
                               input logic        [svf_pkg::DAMP_W-1:0]   q,
                               input logic signed [svf_pkg::GAIN_W-1:0]   g);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_sample_in  <= x;
        s_freq_coeff <= f;
        s_damp_coeff <= q;
        s_gain_in    <= g;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (expected_responses.size() != 0);
    endtask

    function automatic logic signed [svf_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return svf_pkg::SAMPLE_W'(SAMPLE_LIM - 1);
            1:       return svf_pkg::SAMPLE_W'(-SAMPLE_LIM);
            2:       return svf_pkg::SAMPLE_W'(int'($urandom_range(8191)) - 4096);
            default: return svf_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample(svf_pkg::SAMPLE_W'(SAMPLE_LIM - 1), '0, '0, svf_pkg::GAIN_W'(4096));
        send_sample(svf_pkg::SAMPLE_W'(-SAMPLE_LIM), svf_pkg::FREQ_W'(131072),
                    svf_pkg::DAMP_MAX, svf_pkg::GAIN_W'(32767));
        // frequency above two, damping above eight, most negative gain
        send_sample(svf_pkg::SAMPLE_W'(SAMPLE_LIM - 1), '1, '1, svf_pkg::GAIN_W'(-32768));
        send_sample('0, svf_pkg::FREQ_W'(65536), svf_pkg::DAMP_W'(65536), '0);
        send_sample(svf_pkg::SAMPLE_W'(-SAMPLE_LIM), '0, svf_pkg::DAMP_W'(524289),
                    svf_pkg::GAIN_W'(-1));
        // undamped, maximum frequency: runs away into overflow and recovers
        for (int i = 0; i < 16; i++) begin
            send_sample(i[0] ? svf_pkg::SAMPLE_W'(-SAMPLE_LIM)
                             : svf_pkg::SAMPLE_W'(SAMPLE_LIM - 1),
                        '1, '0, svf_pkg::GAIN_W'(4096));
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int count);
        int                                sent;
        int                                run_len;
        bit                                noisy;
        logic        [svf_pkg::FREQ_W-1:0] f;
        logic        [svf_pkg::DAMP_W-1:0] q;
        logic signed [svf_pkg::GAIN_W-1:0] g;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        sent = 0;
        while (sent < count) begin
            noisy = ($urandom_range(4) == 0);
            f = svf_pkg::FREQ_W'($urandom_range(60000));
            q = svf_pkg::DAMP_W'($urandom_range(200000, 20000));
            g = svf_pkg::GAIN_W'(int'($urandom_range(16384)) - 8192);
            if ($urandom_range(9) == 0) begin
                f = svf_pkg::FREQ_W'($urandom_range(131072));
                q = svf_pkg::DAMP_W'($urandom_range(524288));
            end
            run_len = $urandom_range(40, 8);
            repeat (run_len) begin
                if (noisy) begin
                    send_sample(svf_pkg::SAMPLE_W'($urandom), svf_pkg::FREQ_W'($urandom),
                                svf_pkg::DAMP_W'($urandom), svf_pkg::GAIN_W'($urandom));
                end else begin
                    send_sample(random_sample(), f, q, g);
                end
                sent++;
            end
        end
        wait_for_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_requested++;
        repeat (40) begin
            send_sample(random_sample(), svf_pkg::FREQ_W'($urandom_range(40000)),
                        svf_pkg::DAMP_W'($urandom_range(150000, 30000)),
                        svf_pkg::GAIN_W'(4096));
        end
        wait_for_results();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_traffic(0, 0, 290);
        test_random_traffic(58, 0, 290);
        test_backpressure();
        test_random_traffic(0, 58, 290);
        test_random_traffic(29, 29, 290);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_responses.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/svf_pkg.sv
src/svf_mul.sv
src/state_variable_filter.sv
sim/state_variable_filter_tb.sv
